/* rtl/core/vcdg_pkg.sv */
// Shared widths, codes and the sequencer control store for the voxel gradient block.
package vcdg_pkg;

  localparam int COORD_W = 5;
  localparam int SIZE_W = 6;
  localparam int RECIP_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int GRAD_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W = 4;

  localparam int DEF_MAX_DIM_X = 32;
  localparam int DEF_MAX_DIM_Y = 32;
  localparam int DEF_MAX_DIM_Z = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd256;

  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_XP = 3'd1;
  localparam logic [2:0] RD_XM = 3'd2;
  localparam logic [2:0] RD_YP = 3'd3;
  localparam logic [2:0] RD_YM = 3'd4;
  localparam logic [2:0] RD_ZP = 3'd5;
  localparam logic [2:0] RD_ZM = 3'd6;

  localparam logic [1:0] AX_NONE = 2'd0;
  localparam logic [1:0] AX_X = 2'd1;
  localparam logic [1:0] AX_Y = 2'd2;
  localparam logic [1:0] AX_Z = 2'd3;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WR = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FIN = 4'd2;
  localparam logic [STEP_W-1:0] STEP_Q1 = 4'd3;
  localparam logic [STEP_W-1:0] STEP_Q2 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_Q3 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_Q4 = 4'd6;
  localparam logic [STEP_W-1:0] STEP_Q5 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_Q6 = 4'd8;
  localparam logic [STEP_W-1:0] STEP_Q7 = 4'd9;
  localparam logic [STEP_W-1:0] STEP_Q8 = 4'd10;
  localparam logic [STEP_W-1:0] STEP_Q9 = 4'd11;

  typedef struct packed {
    logic [2:0] rd;
    logic load_a;
    logic sub;
    logic [1:0] mul;
    logic [1:0] rnd;
    logic wr;
    logic emit;
    logic disp;
    logic [STEP_W-1:0] nxt;
  } uc_t;

  function automatic uc_t uc_word(input logic [STEP_W-1:0] step);
    uc_t w;
    w = '{rd: RD_NONE, load_a: 1'b0, sub: 1'b0, mul: AX_NONE, rnd: AX_NONE,
          wr: 1'b0, emit: 1'b0, disp: 1'b0, nxt: STEP_IDLE};
    case (step)
      STEP_IDLE: w.disp = 1'b1;
      STEP_WR: begin
        w.wr = 1'b1;
        w.emit = 1'b1;
      end
      STEP_FIN: w.emit = 1'b1;
      STEP_Q1: begin
        w.rd = RD_XP;
        w.nxt = STEP_Q2;
      end
      STEP_Q2: begin
        w.rd = RD_XM;
        w.load_a = 1'b1;
        w.nxt = STEP_Q3;
      end
      STEP_Q3: begin
        w.rd = RD_YP;
        w.sub = 1'b1;
        w.nxt = STEP_Q4;
      end
      STEP_Q4: begin
        w.rd = RD_YM;
        w.load_a = 1'b1;
        w.mul = AX_X;
        w.nxt = STEP_Q5;
      end
      STEP_Q5: begin
        w.rd = RD_ZP;
        w.sub = 1'b1;
        w.rnd = AX_X;
        w.nxt = STEP_Q6;
      end
      STEP_Q6: begin
        w.rd = RD_ZM;
        w.load_a = 1'b1;
        w.mul = AX_Y;
        w.nxt = STEP_Q7;
      end
      STEP_Q7: begin
        w.sub = 1'b1;
        w.rnd = AX_Y;
        w.nxt = STEP_Q8;
      end
      STEP_Q8: begin
        w.mul = AX_Z;
        w.nxt = STEP_Q9;
      end
      STEP_Q9: begin
        w.rnd = AX_Z;
        w.emit = 1'b1;
      end
      default: w.disp = 1'b1;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/voxel_central_difference_gradient.sv */
// Top level of the voxel store with central-difference gradient queries.
// A transaction is taken when start is high and busy is low; its single result appears on
// the out_ ports for one cycle with out_valid, and must be taken in that cycle. A write
// or any item with an out-of-range coordinate gives its result from STEP_WR or STEP_FIN;
// a valid query runs STEP_Q1 to STEP_Q9 for six reads of the single-ported voxel memory
// in turn and one multiplier shared by the three axes. A new transaction can be taken in
// the cycle that shows the result. After reset the memory is cleared one entry a cycle,
// MAX_DIM_X*MAX_DIM_Y*MAX_DIM_Z entries (32768 by default), with busy high; configuration
// writes are taken at any time, cfg_ready being always high.
module voxel_central_difference_gradient
  import vcdg_pkg::*;
#(
  parameter int MAX_DIM_X = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [COORD_W-1:0]          in_coord_x,
  input  logic [COORD_W-1:0]          in_coord_y,
  input  logic [COORD_W-1:0]          in_coord_z,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  output logic signed [GRAD_W-1:0]    out_grad_x,
  output logic signed [GRAD_W-1:0]    out_grad_y,
  output logic signed [GRAD_W-1:0]    out_grad_z,
  output logic                        out_status,
  output logic                        out_grid_empty,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int AW = $clog2(DEPTH);
  localparam int NB_W = COORD_W + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + RECIP_W + 1;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [RECIP_W-1:0] recip_x_r, recip_y_r, recip_z_r;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic clr_act_r;
  logic [AW-1:0] clr_addr_r;

  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic bad_r, empty_r;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [SAMPLE_W-1:0] op_a_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gz_r;
  logic out_valid_r;

  uc_t uc;
  logic accept;
  logic [SIZE_W-1:0] nx, ny, nz;
  logic bad, empty;
  logic [NB_W-1:0] xp, xm, yp, ym, zp, zm;
  logic [NB_W-1:0] ax, ay, az;
  logic [31:0] lin_addr;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic [RECIP_W-1:0] mul_recip;
  logic signed [GRAD_W-1:0] rnd_val;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s, input int max_dim);
    logic [SIZE_W-1:0] r;
    if (32'(s) > 32'(max_dim)) begin
      r = SIZE_W'(max_dim);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [NB_W-1:0] nb_up(input logic [COORD_W-1:0] c,
                                           input logic [SIZE_W-1:0] n);
    logic [NB_W-1:0] p;
    p = {1'b0, c} + NB_W'(1);
    return (p == n) ? {1'b0, c} : p;
  endfunction

  function automatic logic [NB_W-1:0] nb_dn(input logic [COORD_W-1:0] c);
    return (c == '0) ? '0 : {1'b0, c} - NB_W'(1);
  endfunction

  function automatic logic signed [GRAD_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [GRAD_W+1:0] r;
    logic [GRAD_W+1:0] r_neg;
    logic signed [GRAD_W-1:0] res;
    neg = p[PROD_W-1];
    mag = neg ? PROD_W'(-p) : PROD_W'(p);
    sum = mag + PROD_W'(128);
    r = sum[GRAD_W+9:8];
    r_neg = ~r + (GRAD_W+2)'(1);
    if (!neg) begin
      res = (r > (GRAD_W+2)'(24'h7FFFFF)) ? 24'sh7FFFFF : r[GRAD_W-1:0];
    end else begin
      res = (r > (GRAD_W+2)'(25'h800000)) ? 24'sh800000 : r_neg[GRAD_W-1:0];
    end
    return res;
  endfunction

  assign uc = uc_word(pc_r);
  assign busy = clr_act_r || (pc_r != STEP_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = 1'b1;

  assign nx = eff_size(size_x_r, MAX_DIM_X);
  assign ny = eff_size(size_y_r, MAX_DIM_Y);
  assign nz = eff_size(size_z_r, MAX_DIM_Z);
  assign empty = (nx < SIZE_W'(2)) || (ny < SIZE_W'(2)) || (nz < SIZE_W'(2));
  assign bad = ({1'b0, in_coord_x} >= nx) || ({1'b0, in_coord_y} >= ny) ||
               ({1'b0, in_coord_z} >= nz);

  assign xp = nb_up(cx_r, nx);
  assign yp = nb_up(cy_r, ny);
  assign zp = nb_up(cz_r, nz);
  assign xm = nb_dn(cx_r);
  assign ym = nb_dn(cy_r);
  assign zm = nb_dn(cz_r);

  always_comb begin
    ax = {1'b0, cx_r};
    ay = {1'b0, cy_r};
    az = {1'b0, cz_r};
    case (uc.rd)
      RD_XP: ax = xp;
      RD_XM: ax = xm;
      RD_YP: ay = yp;
      RD_YM: ay = ym;
      RD_ZP: az = zp;
      RD_ZM: az = zm;
      default: ;
    endcase
  end

  assign lin_addr = (32'(az) * 32'(MAX_DIM_Y) + 32'(ay)) * 32'(MAX_DIM_X) + 32'(ax);
  assign mem_addr = clr_act_r ? clr_addr_r : lin_addr[AW-1:0];
  assign mem_we = clr_act_r || (uc.wr && !bad_r);
  assign mem_wdata = clr_act_r ? '0 : sample_r;

  always_comb begin
    case (uc.mul)
      AX_Y: mul_recip = recip_y_r;
      AX_Z: mul_recip = recip_z_r;
      default: mul_recip = recip_x_r;
    endcase
  end

  assign rnd_val = round_sat(prod_r);

  always_comb begin
    pc_nxt = uc.nxt;
    if (uc.disp) begin
      if (!accept) begin
        pc_nxt = STEP_IDLE;
      end else if (bad) begin
        pc_nxt = STEP_FIN;
      end else if (in_cmd == CMD_WRITE) begin
        pc_nxt = STEP_WR;
      end else begin
        pc_nxt = STEP_Q1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
      clr_act_r <= 1'b1;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      recip_x_r <= RECIP_RESET;
      recip_y_r <= RECIP_RESET;
      recip_z_r <= RECIP_RESET;
    end else begin
      pc_r <= pc_nxt;
      out_valid_r <= uc.emit;
      if (clr_act_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (32'(clr_addr_r) == 32'(DEPTH - 1)) begin
          clr_act_r <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Y: size_y_r <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Z: size_z_r <= cfg_data[SIZE_W-1:0];
          REG_RECIP_X: recip_x_r <= cfg_data[RECIP_W-1:0];
          REG_RECIP_Y: recip_y_r <= cfg_data[RECIP_W-1:0];
          REG_RECIP_Z: recip_z_r <= cfg_data[RECIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r <= in_coord_x;
      cy_r <= in_coord_y;
      cz_r <= in_coord_z;
      sample_r <= in_sample;
      bad_r <= bad;
      empty_r <= empty;
      gx_r <= '0;
      gy_r <= '0;
      gz_r <= '0;
    end else begin
      case (uc.rnd)
        AX_X: gx_r <= rnd_val;
        AX_Y: gy_r <= rnd_val;
        AX_Z: gz_r <= rnd_val;
        default: ;
      endcase
    end
    if (uc.load_a) begin
      op_a_r <= rd_data_r;
    end
    if (uc.sub) begin
      diff_r <= DIFF_W'(op_a_r) - DIFF_W'(rd_data_r);
    end
    if (uc.mul != AX_NONE) begin
      prod_r <= PROD_W'(diff_r) * $signed({1'b0, mul_recip});
    end
  end

  assign out_valid = out_valid_r;
  assign out_grad_x = gx_r;
  assign out_grad_y = gy_r;
  assign out_grad_z = gz_r;
  assign out_status = bad_r;
  assign out_grid_empty = empty_r;

endmodule

/* rtl/core/vcdg_checker.sv */
// Port-level checks on result timing and content of the voxel gradient block.
module vcdg_checker
  import vcdg_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic signed [GRAD_W-1:0]   out_grad_x,
  input logic signed [GRAD_W-1:0]   out_grad_y,
  input logic signed [GRAD_W-1:0]   out_grad_z,
  input logic                       out_status
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Block not busy after taking a transaction.");

  a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_WRITE) |-> ##2 out_valid)
    else $error("Write result missing two cycles after the transaction.");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Block busy while showing a result.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0))
    else $error("Nonzero gradient with error status.");

endmodule

bind voxel_central_difference_gradient vcdg_checker u_vcdg_checker (.*);
